// ----- hdl/register_window_with_access_census_unit_defines.svh -----
// assertion macros shared by the register window and census logic
`ifndef REGISTER_WINDOW_WITH_ACCESS_CENSUS_UNIT_DEFINES_SVH
`define REGISTER_WINDOW_WITH_ACCESS_CENSUS_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RWAC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rwac assertion failed");

// next-cycle implication, checked outside reset
`define RWAC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rwac assertion failed");

`endif

// ----- hdl/rwac_pkg.sv -----
// shared types, constants and helpers of the register window unit
`timescale 1ns / 1ps

package rwac_pkg;

  localparam int unsigned NumStored       = 7;
  localparam int unsigned SlotW           = 3;
  localparam int unsigned DefCensusDepth  = 8;
  localparam logic [31:0] TxFifoOffset    = 32'h0000_0010;

  localparam logic CmdRead  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  // offsets of the stored registers
  localparam logic [31:0] OffReg0 = 32'h0000_0000;
  localparam logic [31:0] OffReg1 = 32'h0000_0004;
  localparam logic [31:0] OffReg2 = 32'h0000_0008;
  localparam logic [31:0] OffReg3 = 32'h0000_0030;
  localparam logic [31:0] OffReg4 = 32'h0000_0034;
  localparam logic [31:0] OffReg5 = 32'h0000_003c;
  localparam logic [31:0] OffReg6 = 32'h0000_0040;

  // one classified access as it travels from front to back
  typedef struct packed {
    logic             cmd;
    logic [31:0]      offset;
    logic [31:0]      write_data;
    logic [5:0]       census_index;
    logic             hit;
    logic [SlotW-1:0] slot;
    logic             fifo;
  } rwac_item_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hffff_ffff) ? v : v + 32'd1;
  endfunction

endpackage

// ----- hdl/rwac_front.sv -----
// access classifier and two-entry queue toward the execution side
`timescale 1ns / 1ps

module rwac_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic                   cmd_i,
  input  logic [31:0]            offset_i,
  input  logic [31:0]            write_data_i,
  input  logic [5:0]             census_index_i,
  input  logic                   pop_i,
  output logic                   valid_o,
  output rwac_pkg::rwac_item_t   item_o
);

  rwac_pkg::rwac_item_t       item_in;
  rwac_pkg::rwac_item_t       queue_q [2];
  logic                       wr_ptr_q, wr_ptr_d;
  logic                       rd_ptr_q, rd_ptr_d;
  logic [1:0]                 count_q, count_d;
  logic                       push, pop;

  // decode the offset into a stored register slot
  always_comb begin
    item_in.cmd          = cmd_i;
    item_in.offset       = offset_i;
    item_in.write_data   = write_data_i;
    item_in.census_index = census_index_i;
    item_in.hit          = 1'b1;
    unique case (offset_i)
      rwac_pkg::OffReg0: item_in.slot = 3'd0;
      rwac_pkg::OffReg1: item_in.slot = 3'd1;
      rwac_pkg::OffReg2: item_in.slot = 3'd2;
      rwac_pkg::OffReg3: item_in.slot = 3'd3;
      rwac_pkg::OffReg4: item_in.slot = 3'd4;
      rwac_pkg::OffReg5: item_in.slot = 3'd5;
      rwac_pkg::OffReg6: item_in.slot = 3'd6;
      default: begin
        item_in.slot = 3'd0;
        item_in.hit  = 1'b0;
      end
    endcase
    // a stored register at the fifo offset would take precedence
    item_in.fifo = (offset_i == rwac_pkg::TxFifoOffset) && !item_in.hit;
  end

  assign busy_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = queue_q[rd_ptr_q];
  assign push    = start_i && !busy_o;
  assign pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ----- hdl/rwac_back.sv -----
// execution side: stored registers, counters, census list and result registers
`timescale 1ns / 1ps

`include "register_window_with_access_census_unit_defines.svh"

module rwac_back #(
  parameter int unsigned CENSUS_DEPTH = rwac_pkg::DefCensusDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  rwac_pkg::rwac_item_t   item_i,
  output logic                   pop_o,
  output logic                   done_o,
  output logic [31:0]            read_data_o,
  output logic                   hit_o,
  output logic                   tx_push_o,
  output logic [31:0]            tx_word_o,
  output logic [31:0]            read_count_o,
  output logic [31:0]            write_count_o,
  output logic [31:0]            unknown_read_count_o,
  output logic [31:0]            unknown_write_count_o,
  output logic [31:0]            tx_word_count_o,
  output logic [6:0]             census_fill_o,
  output logic [31:0]            census_entry_o
);

  localparam int unsigned FillW = $clog2(CENSUS_DEPTH + 1);
  localparam int unsigned IdxW  = (CENSUS_DEPTH > 1) ? $clog2(CENSUS_DEPTH) : 1;

  rwac_pkg::rwac_item_t  stage_q;
  logic                  stage_valid_q;

  logic [31:0]           regs_q [rwac_pkg::NumStored];
  logic [31:0]           list_q [CENSUS_DEPTH];
  logic [31:0]           list_d [CENSUS_DEPTH];
  logic [FillW-1:0]      fill_q, fill_d;

  logic [31:0]           rd_cnt_q, wr_cnt_q, urd_cnt_q, uwr_cnt_q, tx_cnt_q;

  logic                  done_q;
  logic [31:0]           read_data_q, read_data_d;
  logic                  hit_q;
  logic                  tx_push_q, tx_push_d;
  logic [31:0]           tx_word_q;
  logic [31:0]           entry_q, entry_d;

  logic                  is_wr;
  logic                  match;
  logic                  append;

  // the stage drains every cycle, so the queue head is always taken
  assign pop_o = valid_i;
  assign is_wr = (stage_q.cmd == rwac_pkg::CmdWrite);

  always_comb begin
    match = 1'b0;
    for (int unsigned i = 0; i < CENSUS_DEPTH; i++) begin
      if ((FillW'(i) < fill_q) && (list_q[i] == stage_q.offset)) begin
        match = 1'b1;
      end
    end
    append = stage_valid_q && !stage_q.hit && !match && (fill_q < FillW'(CENSUS_DEPTH));

    list_d = list_q;
    fill_d = fill_q;
    if (append) begin
      list_d[fill_q[IdxW-1:0]] = stage_q.offset;
      fill_d                   = FillW'(fill_q + 1'b1);
    end

    // census entry reflects the list after this access
    if ({1'b0, stage_q.census_index} < 7'(fill_d)) begin
      entry_d = list_d[stage_q.census_index[IdxW-1:0]];
    end else begin
      entry_d = '0;
    end

    read_data_d = (!is_wr && stage_q.hit) ? regs_q[stage_q.slot] : '0;
    tx_push_d   = is_wr && stage_q.fifo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      done_q        <= 1'b0;
      fill_q        <= '0;
      rd_cnt_q      <= '0;
      wr_cnt_q      <= '0;
      urd_cnt_q     <= '0;
      uwr_cnt_q     <= '0;
      tx_cnt_q      <= '0;
      for (int unsigned i = 0; i < rwac_pkg::NumStored; i++) begin
        regs_q[i] <= '0;
      end
    end else begin
      stage_valid_q <= valid_i;
      done_q        <= stage_valid_q;
      fill_q        <= fill_d;
      if (stage_valid_q) begin
        if (is_wr) begin
          wr_cnt_q <= rwac_pkg::sat_inc(wr_cnt_q);
          if (stage_q.hit) begin
            regs_q[stage_q.slot] <= stage_q.write_data;
          end else begin
            uwr_cnt_q <= rwac_pkg::sat_inc(uwr_cnt_q);
          end
          if (stage_q.fifo) begin
            tx_cnt_q <= rwac_pkg::sat_inc(tx_cnt_q);
          end
        end else begin
          rd_cnt_q <= rwac_pkg::sat_inc(rd_cnt_q);
          if (!stage_q.hit) begin
            urd_cnt_q <= rwac_pkg::sat_inc(urd_cnt_q);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= item_i;
    end
    list_q <= list_d;
    if (stage_valid_q) begin
      read_data_q <= read_data_d;
      hit_q       <= stage_q.hit;
      tx_push_q   <= tx_push_d;
      tx_word_q   <= tx_push_d ? stage_q.write_data : '0;
      entry_q     <= entry_d;
    end
  end

  assign done_o                = done_q;
  assign read_data_o           = read_data_q;
  assign hit_o                 = hit_q;
  assign tx_push_o             = tx_push_q;
  assign tx_word_o             = tx_word_q;
  assign read_count_o          = rd_cnt_q;
  assign write_count_o         = wr_cnt_q;
  assign unknown_read_count_o  = urd_cnt_q;
  assign unknown_write_count_o = uwr_cnt_q;
  assign tx_word_count_o       = tx_cnt_q;
  assign census_fill_o         = 7'(fill_q);
  assign census_entry_o        = entry_q;

  `RWAC_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FillW'(CENSUS_DEPTH))
  `RWAC_ASSERT_NEXT(a_fill_monotonic, 1'b1, fill_q >= $past(fill_q))
  `RWAC_ASSERT_NEXT(a_exec_strobes, stage_valid_q, done_q)
  `RWAC_ASSERT_NOW(a_push_not_hit, done_q && tx_push_q, !hit_q)
  `RWAC_ASSERT_NOW(a_rdata_needs_hit, done_q && (read_data_q != 32'd0), hit_q)

endmodule

// ----- hdl/register_window_with_access_census_unit.sv -----
// top level of the register window with access census
//
//  channel   direction  handshake            payload
//  access    in         start_i / busy_o     cmd_i, offset_i, write_data_i, census_index_i
//  result    out        done_o (strobe)      read_data_o .. census_entry_o
//
// an access is taken on a clock edge with start_i high and busy_o low
// the result strobe done_o follows through the queue, the stage register and the result registers, and lasts one cycle
// up to one access per clock: the back side takes the queue head every cycle,
// so the two-entry queue never holds more than one access and busy_o stays low
// reset clears stored registers, counters and the census fill at once
// results cannot be held off by the receiver; each strobe is one transfer
`timescale 1ns / 1ps

module register_window_with_access_census_unit #(
  // number of census list entries, 1 to 64
  parameter int unsigned CENSUS_DEPTH = rwac_pkg::DefCensusDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // access channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cmd_i,
  input  logic [31:0] offset_i,
  input  logic [31:0] write_data_i,
  input  logic [5:0]  census_index_i,
  // result channel
  output logic        done_o,
  output logic [31:0] read_data_o,
  output logic        hit_o,
  output logic        tx_push_o,
  output logic [31:0] tx_word_o,
  output logic [31:0] read_count_o,
  output logic [31:0] write_count_o,
  output logic [31:0] unknown_read_count_o,
  output logic [31:0] unknown_write_count_o,
  output logic [31:0] tx_word_count_o,
  output logic [6:0]  census_fill_o,
  output logic [31:0] census_entry_o
);

  // classified access leaving the queue head
  rwac_pkg::rwac_item_t q_item;
  logic                 q_valid;
  logic                 q_pop;

  // front: offset decode and the queue that decouples it from execution
  rwac_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .offset_i       (offset_i),
    .write_data_i   (write_data_i),
    .census_index_i (census_index_i),
    .pop_i          (q_pop),
    .valid_o        (q_valid),
    .item_o         (q_item)
  );

  // back: register file, saturating counters, dedup census and result registers
  rwac_back #(
    .CENSUS_DEPTH (CENSUS_DEPTH)
  ) u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .valid_i               (q_valid),
    .item_i                (q_item),
    .pop_o                 (q_pop),
    .done_o                (done_o),
    .read_data_o           (read_data_o),
    .hit_o                 (hit_o),
    .tx_push_o             (tx_push_o),
    .tx_word_o             (tx_word_o),
    .read_count_o          (read_count_o),
    .write_count_o         (write_count_o),
    .unknown_read_count_o  (unknown_read_count_o),
    .unknown_write_count_o (unknown_write_count_o),
    .tx_word_count_o       (tx_word_count_o),
    .census_fill_o         (census_fill_o),
    .census_entry_o        (census_entry_o)
  );

endmodule

// ----- dv/register_window_with_access_census_unit_tb.sv -----
// self-checking testbench of the register window with access census unit
`timescale 1ns / 1ps

module register_window_with_access_census_unit_tb;

  localparam int unsigned CensusDepth   = rwac_pkg::DefCensusDepth;
  localparam int unsigned RandomItems   = 1350;
  // limit on a run of cycles with neither an access transfer nor a result
  localparam int unsigned WatchdogLimit = 500;
  // cycles waited after the last awaited result before the verdict
  localparam int unsigned TailCycles    = 8;

  // unmapped offsets used to fill the census: fifo, top of space, unaligned, gaps
  localparam logic [31:0] StrayOffsets [8] = '{
    32'h0000_0010, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0044,
    32'h0000_000c, 32'h0000_002c, 32'h0000_0038, 32'h8000_0000
  };
  localparam logic [31:0] WritePatterns [7] = '{
    32'hffff_ffff, 32'h0000_0000, 32'ha5a5_a5a5, 32'h5a5a_5a5a,
    32'h1234_5678, 32'h8000_0001, 32'hfedc_ba98
  };

  // one result as seen on the result ports
  typedef struct {
    logic [31:0] read_data;
    logic        hit;
    logic        tx_push;
    logic [31:0] tx_word;
    logic [31:0] read_count;
    logic [31:0] write_count;
    logic [31:0] unknown_read_count;
    logic [31:0] unknown_write_count;
    logic [31:0] tx_word_count;
    logic [6:0]  census_fill;
    logic [31:0] census_entry;
  } window_result_t;

  // offset of stored register n
  function automatic logic [31:0] stored_offset(input int unsigned n);
    case (n)
      0: return rwac_pkg::OffReg0;
      1: return rwac_pkg::OffReg1;
      2: return rwac_pkg::OffReg2;
      3: return rwac_pkg::OffReg3;
      4: return rwac_pkg::OffReg4;
      5: return rwac_pkg::OffReg5;
      default: return rwac_pkg::OffReg6;
    endcase
  endfunction

  // mirror of the window state; predicts each result and checks it in order
  class census_scoreboard;
    logic [31:0] stored_words [rwac_pkg::NumStored];
    logic [31:0] reads_seen;
    logic [31:0] writes_seen;
    logic [31:0] stray_reads_seen;
    logic [31:0] stray_writes_seen;
    logic [31:0] words_pushed;
    logic [31:0] census_list [CensusDepth];
    int unsigned census_len;
    window_result_t awaited_results [$];
    int unsigned mismatches;

    function new();
      foreach (stored_words[i]) stored_words[i] = '0;
      foreach (census_list[i]) census_list[i] = '0;
      reads_seen        = '0;
      writes_seen       = '0;
      stray_reads_seen  = '0;
      stray_writes_seen = '0;
      words_pushed      = '0;
      census_len        = 0;
      mismatches        = 0;
    endfunction

    function logic [31:0] bump(input logic [31:0] v);
      return (v == 32'hffff_ffff) ? v : v + 32'd1;
    endfunction

    // record an unmapped offset once, while there is room
    function void log_stray(input logic [31:0] off);
      bit seen;
      seen = 1'b0;
      for (int unsigned i = 0; i < census_len; i++)
        if (census_list[i] == off) seen = 1'b1;
      if (!seen && census_len < CensusDepth) begin
        census_list[census_len] = off;
        census_len++;
      end
    endfunction

    function void note_access(input logic cmd, input logic [31:0] off,
                              input logic [31:0] data, input logic [5:0] idx);
      window_result_t r;
      int slot;
      slot = -1;
      for (int i = 0; i < rwac_pkg::NumStored; i++)
        if (slot < 0 && stored_offset(i) == off) slot = i;
      r.read_data = '0;
      r.tx_push   = 1'b0;
      r.tx_word   = '0;
      r.hit       = (slot >= 0);
      if (cmd == rwac_pkg::CmdRead) begin
        reads_seen = bump(reads_seen);
        if (slot >= 0) begin
          r.read_data = stored_words[slot];
        end else begin
          stray_reads_seen = bump(stray_reads_seen);
          log_stray(off);
        end
      end else begin
        writes_seen = bump(writes_seen);
        if (slot >= 0) begin
          stored_words[slot] = data;
        end else begin
          // a stored register at the fifo offset would have won above
          if (off == rwac_pkg::TxFifoOffset) begin
            words_pushed = bump(words_pushed);
            r.tx_push    = 1'b1;
            r.tx_word    = data;
          end
          stray_writes_seen = bump(stray_writes_seen);
          log_stray(off);
        end
      end
      r.read_count          = reads_seen;
      r.write_count         = writes_seen;
      r.unknown_read_count  = stray_reads_seen;
      r.unknown_write_count = stray_writes_seen;
      r.tx_word_count       = words_pushed;
      r.census_fill         = census_len[6:0];
      r.census_entry        = (idx < census_len) ? census_list[idx] : '0;
      awaited_results.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(input window_result_t got);
      window_result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: result with no access waiting, expected none actual read_data %h",
                 $time, got.read_data);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("hit", want.hit, got.hit);
      compare_field("tx_push", want.tx_push, got.tx_push);
      compare_field("tx_word", want.tx_word, got.tx_word);
      compare_field("read_count", want.read_count, got.read_count);
      compare_field("write_count", want.write_count, got.write_count);
      compare_field("unknown_read_count", want.unknown_read_count, got.unknown_read_count);
      compare_field("unknown_write_count", want.unknown_write_count,
                    got.unknown_write_count);
      compare_field("tx_word_count", want.tx_word_count, got.tx_word_count);
      compare_field("census_fill", want.census_fill, got.census_fill);
      compare_field("census_entry", want.census_entry, got.census_entry);
    endfunction

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        cmd_i;
  logic [31:0] offset_i;
  logic [31:0] write_data_i;
  logic [5:0]  census_index_i;
  logic        done_o;
  logic [31:0] read_data_o;
  logic        hit_o;
  logic        tx_push_o;
  logic [31:0] tx_word_o;
  logic [31:0] read_count_o;
  logic [31:0] write_count_o;
  logic [31:0] unknown_read_count_o;
  logic [31:0] unknown_write_count_o;
  logic [31:0] tx_word_count_o;
  logic [6:0]  census_fill_o;
  logic [31:0] census_entry_o;

  census_scoreboard scoreboard = new();
  bit               no_idle;       // when set, accesses go back to back
  int unsigned      idle_cycles;

  register_window_with_access_census_unit #(
    .CENSUS_DEPTH(CensusDepth)
  ) i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start_i),
    .busy_o               (busy_o),
    .cmd_i                (cmd_i),
    .offset_i             (offset_i),
    .write_data_i         (write_data_i),
    .census_index_i       (census_index_i),
    .done_o               (done_o),
    .read_data_o          (read_data_o),
    .hit_o                (hit_o),
    .tx_push_o            (tx_push_o),
    .tx_word_o            (tx_word_o),
    .read_count_o         (read_count_o),
    .write_count_o        (write_count_o),
    .unknown_read_count_o (unknown_read_count_o),
    .unknown_write_count_o(unknown_write_count_o),
    .tx_word_count_o      (tx_word_count_o),
    .census_fill_o        (census_fill_o),
    .census_entry_o       (census_entry_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one access transfer: optional idle gap, drive on the falling edge, then
  // hold until a rising edge sees busy_o low
  // start_i stays high after the transfer so a zero gap keeps it asserted
  task automatic send_access(input logic cmd, input logic [31:0] off,
                             input logic [31:0] data, input logic [5:0] idx);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i        <= 1'b1;
    cmd_i          <= cmd;
    offset_i       <= off;
    write_data_i   <= data;
    census_index_i <= idx;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    scoreboard.note_access(cmd, off, data, idx);
  endtask

  // offsets biased toward the window, the fifo and the offsets already logged
  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return stored_offset($urandom_range(0, rwac_pkg::NumStored - 1));
      4:          return rwac_pkg::TxFifoOffset;
      5, 6:       return StrayOffsets[$urandom_range(0, 7)];
      7:          return {24'd0, 3'($urandom_range(0, 7)), 5'($urandom_range(0, 31))};
      default:    return $urandom;
    endcase
  endfunction

  // results cannot be stalled: every strobe is checked at the edge ending it
  always @(posedge clk_i) begin : result_monitor
    window_result_t got;
    if (rst_ni && done_o === 1'b1) begin
      got.read_data           = read_data_o;
      got.hit                 = hit_o;
      got.tx_push             = tx_push_o;
      got.tx_word             = tx_word_o;
      got.read_count          = read_count_o;
      got.write_count         = write_count_o;
      got.unknown_read_count  = unknown_read_count_o;
      got.unknown_write_count = unknown_write_count_o;
      got.tx_word_count       = tx_word_count_o;
      got.census_fill         = census_fill_o;
      got.census_entry        = census_entry_o;
      scoreboard.check_result(got);
    end
  end

  // watchdog: counts cycles with neither an access transfer nor a result
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    logic        cmd;
    logic [31:0] off;
    logic [5:0]  idx;
    int unsigned sent;

    rst_ni         = 1'b0;
    start_i        = 1'b0;
    cmd_i          = rwac_pkg::CmdRead;
    offset_i       = '0;
    write_data_i   = '0;
    census_index_i = '0;
    no_idle        = 1'b0;
    idle_cycles    = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset values, every stored register written with a pattern and read back
    send_access(rwac_pkg::CmdRead, rwac_pkg::OffReg0, 32'hffff_ffff, 6'd0);
    for (int i = 0; i < rwac_pkg::NumStored; i++)
      send_access(rwac_pkg::CmdWrite, stored_offset(i), WritePatterns[i], 6'(i));
    for (int i = 0; i < rwac_pkg::NumStored; i++)
      send_access(rwac_pkg::CmdRead, stored_offset(i), ~WritePatterns[i], 6'(i + 1));

    // fifo push, then fill the census with duplicates and distinct strays
    send_access(rwac_pkg::CmdWrite, rwac_pkg::TxFifoOffset, 32'hdead_beef, 6'd0);
    for (int k = 0; k < 8; k++)
      send_access(k[0] ? rwac_pkg::CmdWrite : rwac_pkg::CmdRead, StrayOffsets[k],
                  ~WritePatterns[k % 7], (k == 7) ? 6'd63 : 6'(k));
    // census full: new strays counted only, index at depth and just inside it
    send_access(rwac_pkg::CmdRead, 32'h0000_0100, 32'h0, 6'd8);
    send_access(rwac_pkg::CmdWrite, 32'h0000_0104, 32'hffff_ffff, 6'd7);
    send_access(rwac_pkg::CmdRead, rwac_pkg::OffReg6, 32'h0, 6'd6);

    // random: single accesses of either kind, and at times a write followed by a readback of the same offset
    sent = 0;
    while (sent < RandomItems) begin
      no_idle = ((sent / 50) % 4 == 1);
      off = pick_offset();
      idx = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                        : 6'($urandom_range(0, CensusDepth + 1));
      if ($urandom_range(0, 3) == 0) begin
        send_access(rwac_pkg::CmdWrite, off, $urandom, idx);
        send_access(rwac_pkg::CmdRead, off, $urandom, 6'($urandom_range(0, 63)));
        sent += 2;
      end else begin
        cmd = 1'($urandom_range(0, 1));
        send_access(cmd, off, $urandom, idx);
        sent++;
      end
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (scoreboard.outstanding() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (scoreboard.mismatches == 0 && scoreboard.outstanding() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/rwac_pkg.sv
hdl/rwac_front.sv
hdl/rwac_back.sv
hdl/register_window_with_access_census_unit.sv
dv/register_window_with_access_census_unit_tb.sv
